// File: hw/rtl/tdr_pkg.sv
// Shared types, constants and character functions for the text display RAM decoder.
package tdr_pkg;

   // Display geometry
   localparam int LINE_LENGTH = 40;
   localparam int CELL_COUNT  = 2 * LINE_LENGTH;
   localparam int IDX_W       = $clog2(CELL_COUNT);
   localparam int CUR_W       = $clog2(CELL_COUNT + 1);

   // Port field widths
   localparam int CMD_W  = 2;
   localparam int BYTE_W = 8;
   localparam int RIDX_W = 7;
   localparam int POS_W  = 7;

   // Item commands
   typedef enum logic [CMD_W-1:0] {
      CMD_FRAME = 2'd0,
      CMD_WORD  = 2'd1,
      CMD_READ  = 2'd2
   } cmd_type;

   // Display word types and command codes
   localparam logic [BYTE_W-1:0] TYPE_CHAR  = 8'h03;
   localparam logic [BYTE_W-1:0] TYPE_CMD   = 8'h02;
   localparam logic [BYTE_W-1:0] CODE_CLEAR = 8'h06;
   localparam logic [BYTE_W-1:0] CODE_HOME1 = 8'h02;
   localparam logic [BYTE_W-1:0] CODE_HOME2 = 8'hc0;

   // Special symbols and their stand-ins
   localparam logic [BYTE_W-1:0] SYM_BLOCK  = 8'd11;
   localparam logic [BYTE_W-1:0] SYM_ARROW  = 8'd16;
   localparam logic [BYTE_W-1:0] SYM_AT     = 8'd22;
   localparam logic [BYTE_W-1:0] SYM_BLANK  = 8'd145;
   localparam logic [BYTE_W-1:0] SYM_CIRCLE = 8'd152;
   localparam logic [BYTE_W-1:0] CHR_HASH   = 8'h23;
   localparam logic [BYTE_W-1:0] CHR_GT     = 8'h3e;
   localparam logic [BYTE_W-1:0] CHR_AT     = 8'h40;
   localparam logic [BYTE_W-1:0] CHR_O      = 8'h6f;
   localparam logic [BYTE_W-1:0] CHR_SPACE  = 8'h20;
   localparam logic [BYTE_W-1:0] CHR_TILDE  = 8'h7e;

   // Store write request from the control path
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_addr;
      logic [BYTE_W-1:0] wr_data;
      logic             clear;
   } store_wr_type;

   // Store read request
   typedef struct packed {
      logic              rd_en;
      logic [RIDX_W-1:0] rd_addr;
   } store_rd_type;

   // True for one of the five kept symbols
   function automatic logic is_special(input logic [BYTE_W-1:0] c);
      return (c == SYM_BLOCK) || (c == SYM_ARROW) || (c == SYM_AT) ||
             (c == SYM_BLANK) || (c == SYM_CIRCLE);
   endfunction

   // Non-printable codes other than the symbols are stored as space
   function automatic logic [BYTE_W-1:0] filter_char(input logic [BYTE_W-1:0] c);
      logic keep;
      keep = is_special(c) || ((c >= CHR_SPACE) && (c <= CHR_TILDE));
      return keep ? c : CHR_SPACE;
   endfunction

   // Map symbols to printable stand-ins on readout
   function automatic logic [BYTE_W-1:0] printable(input logic [BYTE_W-1:0] c);
      logic [BYTE_W-1:0] r;
      unique case (c)
         SYM_BLOCK:  r = CHR_HASH;
         SYM_ARROW:  r = CHR_GT;
         SYM_AT:     r = CHR_AT;
         SYM_BLANK:  r = CHR_SPACE;
         SYM_CIRCLE: r = CHR_O;
         default:    r = c;
      endcase
      return r;
   endfunction

endpackage

// File: hw/rtl/tdr_req_if.sv
// Request channel interface: valid/ready with one decoder input item.
interface tdr_req_if;
   logic                       valid;
   logic                       ready;
   logic [tdr_pkg::CMD_W-1:0]  cmd;
   logic [tdr_pkg::BYTE_W-1:0] word_type;
   logic [tdr_pkg::BYTE_W-1:0] word_code;
   logic [tdr_pkg::RIDX_W-1:0] read_index;

   modport source (output valid, cmd, word_type, word_code, read_index, input ready);
   modport sink   (input valid, cmd, word_type, word_code, read_index, output ready);
endinterface

// File: hw/rtl/tdr_rsp_if.sv
// Response channel interface: valid/ready with one decoder result item.
interface tdr_rsp_if;
   logic                       valid;
   logic                       ready;
   logic [tdr_pkg::BYTE_W-1:0] cell_char;
   logic [tdr_pkg::POS_W-1:0]  cursor_pos;

   modport source (output valid, cell_char, cursor_pos, input ready);
   modport sink   (input valid, cell_char, cursor_pos, output ready);
endinterface

// File: hw/rtl/tdr_cell_store.sv
// Character cell memory with per-cell written flags and a registered read port.
module tdr_cell_store (
   input  logic                       clock,
   input  logic                       reset,
   input  tdr_pkg::store_wr_type      wr,
   input  tdr_pkg::store_rd_type      rd,
   output logic                       rd_hit,
   output logic [tdr_pkg::BYTE_W-1:0] rd_data
);

   logic [tdr_pkg::BYTE_W-1:0]     mem [tdr_pkg::CELL_COUNT];
   logic [tdr_pkg::CELL_COUNT-1:0] written_ff;
   logic [tdr_pkg::CELL_COUNT-1:0] written_in;
   logic                           hit_ff;
   logic                           hit_in;
   logic [tdr_pkg::BYTE_W-1:0]     data_ff;
   logic                           in_range;

   // Flag update: a clear wipes every flag, a write sets one
   always_comb begin
      written_in = written_ff;
      if (wr.clear) begin
         written_in = '0;
      end else if (wr.wr_en) begin
         written_in[wr.wr_addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else begin
         written_ff <= written_in;
      end
   end

   // Cell memory write port
   always_ff @(posedge clock) begin
      if (wr.wr_en) begin
         mem[wr.wr_addr] <= wr.wr_data;
      end
   end

   // Read port: hit means in range and written before this item
   assign in_range = ({1'b0, rd.rd_addr} < (tdr_pkg::RIDX_W + 1)'(tdr_pkg::CELL_COUNT));
   assign hit_in   = in_range && written_ff[rd.rd_addr[tdr_pkg::IDX_W-1:0]];

   always_ff @(posedge clock) begin
      if (rd.rd_en) begin
         data_ff <= mem[rd.rd_addr[tdr_pkg::IDX_W-1:0]];
         hit_ff  <= hit_in;
      end
   end

   assign rd_hit  = hit_ff;
   assign rd_data = data_ff;

endmodule

// File: hw/rtl/text_display_ram_decoder.sv
// Top level: two-line text display memory with cursor, fed by display words.
//
// Input items arrive on req_chan (valid/ready): a frame start blanks the cells and
// homes the cursor, a display word writes a character at the cursor or runs a
// command (clear, home to line one, home to line two), and a read returns one cell.
// Every item gives exactly one result on rsp_chan (valid/ready) carrying the read
// character (zero for non-reads) and the cursor position after the item; a full
// store shows the cursor at the cell count.
// A transfer on req_chan yields its result after it passes through the stage that
// holds the registered cell read and then through the output register.
// Throughput: one item per cycle while rsp_chan takes results; the cell write and
// the registered read both finish in the cycle an item is taken.
// Reset clears the cursor, every written flag and both pipeline stages; cells never
// written read as space. When rsp_chan stalls, the stage and output register fill
// and req_chan.ready drops after two pending results; nothing is lost.
module text_display_ram_decoder (
   input  logic      clock,
   input  logic      reset,
   tdr_req_if.sink   req_chan,
   tdr_rsp_if.source rsp_chan
);

   logic                          accept;
   logic                          s1_advance;
   logic [tdr_pkg::CUR_W-1:0]     cursor_ff;
   logic [tdr_pkg::CUR_W-1:0]     cursor_in;
   logic                          not_full;
   logic                          char_wr;
   logic                          do_clear;
   tdr_pkg::cmd_type              cmd;
   tdr_pkg::store_wr_type         store_wr;
   tdr_pkg::store_rd_type         store_rd;
   logic                          rd_hit;
   logic [tdr_pkg::BYTE_W-1:0]    rd_data;
   logic                          s1_valid_ff;
   logic                          s1_valid_in;
   logic                          s1_is_read_ff;
   logic [tdr_pkg::CUR_W-1:0]     s1_cursor_ff;
   logic                          out_valid_ff;
   logic                          out_valid_in;
   logic [tdr_pkg::BYTE_W-1:0]    out_char_ff;
   logic [tdr_pkg::BYTE_W-1:0]    out_char_in;
   logic [tdr_pkg::POS_W-1:0]     out_cursor_ff;

   // Handshake: stage 1 frees when it moves on to the output register
   assign s1_advance     = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !s1_valid_ff || s1_advance;
   assign accept         = req_chan.valid && req_chan.ready;

   assign cmd      = tdr_pkg::cmd_type'(req_chan.cmd);
   assign not_full = (cursor_ff < tdr_pkg::CUR_W'(tdr_pkg::CELL_COUNT));

   // Decode the item: cursor update, store write and clear
   always_comb begin
      cursor_in = cursor_ff;
      char_wr   = 1'b0;
      do_clear  = 1'b0;
      unique case (cmd)
         tdr_pkg::CMD_FRAME: begin
            do_clear  = 1'b1;
            cursor_in = '0;
         end
         tdr_pkg::CMD_WORD: begin
            if (req_chan.word_type == tdr_pkg::TYPE_CHAR) begin
               if (not_full) begin
                  char_wr   = 1'b1;
                  cursor_in = cursor_ff + 1'b1;
               end
            end else if (req_chan.word_type == tdr_pkg::TYPE_CMD) begin
               priority if (req_chan.word_code == tdr_pkg::CODE_CLEAR) begin
                  do_clear = 1'b1;
               end else if (req_chan.word_code == tdr_pkg::CODE_HOME1) begin
                  cursor_in = '0;
               end else if (req_chan.word_code == tdr_pkg::CODE_HOME2) begin
                  cursor_in = tdr_pkg::CUR_W'(tdr_pkg::LINE_LENGTH);
               end else begin
                  cursor_in = cursor_ff;
               end
            end
         end
         default: begin
            cursor_in = cursor_ff;
         end
      endcase
   end

   // Store requests, qualified by the transfer
   always_comb begin
      store_wr.wr_en   = accept && char_wr;
      store_wr.wr_addr = cursor_ff[tdr_pkg::IDX_W-1:0];
      store_wr.wr_data = tdr_pkg::filter_char(req_chan.word_code);
      store_wr.clear   = accept && do_clear;
      store_rd.rd_en   = accept;
      store_rd.rd_addr = req_chan.read_index;
   end

   tdr_cell_store u_store (
      .clock   (clock),
      .reset   (reset),
      .wr      (store_wr),
      .rd      (store_rd),
      .rd_hit  (rd_hit),
      .rd_data (rd_data)
   );

   // Cursor register
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff <= '0;
      end else if (accept) begin
         cursor_ff <= cursor_in;
      end
   end

   // Stage 1: item taken, cell read in flight
   assign s1_valid_in = accept || (s1_valid_ff && !s1_advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_is_read_ff <= (cmd == tdr_pkg::CMD_READ);
         s1_cursor_ff  <= cursor_in;
      end
   end

   // Output register: map the cell and hold until the transfer
   assign out_valid_in = s1_advance ? s1_valid_ff : out_valid_ff;

   always_comb begin
      if (!s1_is_read_ff) begin
         out_char_in = '0;
      end else if (rd_hit) begin
         out_char_in = tdr_pkg::printable(rd_data);
      end else begin
         out_char_in = tdr_pkg::CHR_SPACE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_valid_ff && s1_advance) begin
         out_char_ff   <= out_char_in;
         out_cursor_ff <= tdr_pkg::POS_W'(s1_cursor_ff);
      end
   end

   assign rsp_chan.valid      = out_valid_ff;
   assign rsp_chan.cell_char  = out_char_ff;
   assign rsp_chan.cursor_pos = out_cursor_ff;

   // Cursor never runs past the end of the store
   a_cursor_bound: assert property (@(posedge clock) disable iff (reset)
      cursor_ff <= tdr_pkg::CUR_W'(tdr_pkg::CELL_COUNT))
      else $error("cursor beyond end of store");

   // A stored character advances the cursor by exactly one
   a_char_advance: assert property (@(posedge clock) disable iff (reset)
      store_wr.wr_en |=> (cursor_ff == $past(cursor_ff) + 1'b1))
      else $error("character write did not advance cursor");

   // Both stages full and output stalled: no new transfer taken
   a_full_stall: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && out_valid_ff && !rsp_chan.ready) |-> !req_chan.ready)
      else $error("transfer accepted with pipeline full");

   // A write and a clear never come from the same item
   a_wr_clear: assert property (@(posedge clock) disable iff (reset)
      !(store_wr.wr_en && store_wr.clear))
      else $error("store write and clear in one item");

endmodule
